// ----- sv/assert_macros.svh -----
// Assertion macros shared by the byte ring FIFO RTL.
// Each macro expects the including scope to provide clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BRF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

`define BRF_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/brf_pkg.sv -----
// Types and constants of the byte ring FIFO.
// Used by the controller, the datapath and the top level; depends on nothing.
package brf_pkg;

   localparam logic [1:0] FUNC_WRITE       = 2'd0;
   localparam logic [1:0] FUNC_READ        = 2'd1;
   localparam logic [1:0] FUNC_PEEK_OLDEST = 2'd2;
   localparam logic [1:0] FUNC_PEEK_NEWEST = 2'd3;

   localparam logic [8:0] SIZE_RESET = 9'd256;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       error;
      logic [7:0] free_space;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
      logic cfg_write;
   } brf_cmd_type;

   typedef struct packed {
      logic out_free;
   } brf_stat_type;

endpackage

// ----- sv/byte_ring_fifo.sv -----
// Byte ring FIFO top level: controller plus datapath with the byte store.
// Depends on brf_pkg, brf_ctrl, brf_datapath, brf_ram and assert_macros.svh.
//
// A byte FIFO in a ring of size_in_use slots (clamped to 2..DEPTH) that holds
// at most size_in_use - 1 bytes. Each request beat is a write, read, oldest
// peek or newest peek and yields exactly one response beat with the byte, an
// error flag and the free space after the operation. An operation goes through
// capture, memory access and load of the result register. The block takes no
// new request until the result register has been loaded; the load waits while
// a held response beat is not yet taken. A waiting response does not stop the
// next request from being taken.
// Writing csr_data flushes the FIFO and must only be done while no operation
// is outstanding.
`include "assert_macros.svh"

module byte_ring_fifo #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  brf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output brf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [8:0]       csr_data
);

   brf_pkg::brf_cmd_type  cmd;
   brf_pkg::brf_stat_type stat;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `BRF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "No stall after beat")
   `BRF_ASSERT_IMPLIES(a_no_overwrite, cmd.load, !(rsp_valid && rsp_stall), "Held beat lost")
   `BRF_ASSERT_NEXT(a_load_shows, cmd.load, rsp_valid, "Loaded response not presented")
   `BRF_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.capture, cmd.execute, cmd.load}), "Command overlap")

endmodule

// ----- sv/brf_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package dependency.
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/brf_ctrl.sv -----
// Controller of the byte ring FIFO: sequences capture, execute, load, cfg writes.
// Depends on brf_pkg for the command and status types.
module brf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  brf_pkg::brf_stat_type stat,
   output brf_pkg::brf_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = (state_ff == ST_IDLE);
   assign cmd.capture   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.execute   = (state_ff == ST_EXEC);
   assign cmd.load      = (state_ff == ST_LOAD) && stat.out_free;
   assign cmd.cfg_write = (state_ff == ST_IDLE) && csr_valid;

endmodule

// ----- sv/brf_datapath.sv -----
// Datapath of the byte ring FIFO: pointers, count, size register, byte store
// and the result register. Depends on brf_pkg and brf_ram.
module brf_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  brf_pkg::brf_cmd_type cmd,
   output brf_pkg::brf_stat_type stat,
   input  brf_pkg::req_type     req_data,
   input  logic [8:0]           csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output brf_pkg::rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int SW    = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;
   localparam int FW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

   logic [8:0]       size_ff;
   logic [8:0]       size_in;
   logic [IDX_W-1:0] wr_ptr_ff;
   logic [IDX_W-1:0] wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff;
   logic [IDX_W-1:0] rd_ptr_in;
   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   brf_pkg::req_type op_ff;
   logic             err_ff;
   logic             err_in;
   logic             zero_ff;
   logic             zero_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   brf_pkg::rsp_type rsp_ff;

   logic [SW-1:0]    size_w;
   logic [SW-1:0]    eff_w;
   logic [IDX_W:0]   eff;
   logic [IDX_W:0]   eff_dec;
   logic [IDX_W:0]   wr_inc;
   logic [IDX_W:0]   rd_inc;
   logic [IDX_W:0]   count_inc;
   logic [IDX_W-1:0] wr_bump;
   logic [IDX_W-1:0] rd_bump;
   logic [IDX_W-1:0] newest;
   logic [IDX_W-1:0] rd_addr;
   logic             full;
   logic             empty;
   logic             ram_we;
   logic [7:0]       ram_q;
   logic [FW-1:0]    free_w;

   always_comb begin
      size_w = SW'(size_ff);
      if (size_w < SW'(2)) begin
         eff_w = SW'(2);
      end else if (size_w > SW'(DEPTH)) begin
         eff_w = SW'(DEPTH);
      end else begin
         eff_w = size_w;
      end
   end

   assign eff       = eff_w[IDX_W:0];
   assign eff_dec   = eff - (IDX_W + 1)'(1);
   assign wr_inc    = {1'b0, wr_ptr_ff} + (IDX_W + 1)'(1);
   assign rd_inc    = {1'b0, rd_ptr_ff} + (IDX_W + 1)'(1);
   assign count_inc = {1'b0, count_ff} + (IDX_W + 1)'(1);
   assign wr_bump   = (wr_inc >= eff) ? '0 : wr_inc[IDX_W-1:0];
   assign rd_bump   = (rd_inc >= eff) ? '0 : rd_inc[IDX_W-1:0];
   assign newest    = (wr_ptr_ff == '0) ? eff_dec[IDX_W-1:0] : wr_ptr_ff - IDX_W'(1);
   assign full      = (count_inc >= eff);
   assign empty     = (count_ff == '0);
   assign rd_addr   = (op_ff.func == brf_pkg::FUNC_PEEK_NEWEST) ? newest : rd_ptr_ff;
   assign ram_we    = cmd.execute && (op_ff.func == brf_pkg::FUNC_WRITE) && !full;

   always_comb begin
      size_in   = size_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      zero_in   = zero_ff;
      if (cmd.cfg_write) begin
         size_in   = csr_data;
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end else if (cmd.execute) begin
         case (op_ff.func)
            brf_pkg::FUNC_WRITE: begin
               err_in  = full;
               zero_in = 1'b1;
               if (!full) begin
                  wr_ptr_in = wr_bump;
                  count_in  = count_ff + IDX_W'(1);
               end
            end
            brf_pkg::FUNC_READ: begin
               err_in  = empty;
               zero_in = empty;
               if (!empty) begin
                  rd_ptr_in = rd_bump;
                  count_in  = count_ff - IDX_W'(1);
               end
            end
            default: begin
               err_in  = empty;
               zero_in = empty;
            end
         endcase
      end
   end

   assign free_w       = FW'(eff) - FW'(count_ff) - FW'(1);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= brf_pkg::SIZE_RESET;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff  <= err_in;
      zero_ff <= zero_in;
      if (cmd.capture) begin
         op_ff <= req_data;
      end
      if (cmd.load) begin
         rsp_ff.read_data  <= zero_ff ? 8'd0 : ram_q;
         rsp_ff.error      <= err_ff;
         rsp_ff.free_space <= free_w[7:0];
      end
   end

   brf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (op_ff.write_data),
      .rd_en   (cmd.execute),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- dv/byte_ring_fifo_tb.sv -----
// Self-checking testbench for the byte ring FIFO: directed, size-register,
// back-pressure and random operation tests against an in-bench FIFO predictor.
// Depends on brf_pkg and the byte_ring_fifo RTL only.
`timescale 1ns / 1ps

module byte_ring_fifo_tb;

   localparam int RING_DEPTH  = 256;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_BEATS = 230;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   brf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   brf_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [8:0]       csr_data = '0;

   logic [7:0] ring_mem [RING_DEPTH];
   logic [8:0] ring_size = brf_pkg::SIZE_RESET;
   int         wr_ptr = 0;
   int         rd_ptr = 0;
   int         fill = 0;

   brf_pkg::rsp_type awaited_rsp [$];
   int         fail_count = 0;
   int         cycle_count = 0;
   int         beats_sent = 0;

   bit         tx_idle_on = 1'b1;
   bit         rx_idle_on = 1'b1;
   int         hold_request = 0;
   int         rx_hold_left = 0;
   int         rx_gap_left = 0;

   byte_ring_fifo #(.DEPTH(RING_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic brf_pkg::rsp_type predict_fifo_op(input brf_pkg::req_type beat);
      brf_pkg::rsp_type r;
      int      s;
      int      idx;
      r = '0;
      s = (ring_size < 2) ? 2 : ((ring_size > RING_DEPTH) ? RING_DEPTH : int'(ring_size));
      if (beat.func == brf_pkg::FUNC_WRITE) begin
         if (fill + 1 < s) begin
            ring_mem[wr_ptr] = beat.write_data;
            wr_ptr = (wr_ptr + 1 >= s) ? 0 : wr_ptr + 1;
            fill++;
         end else begin
            r.error = 1'b1;
         end
      end else if (fill == 0) begin
         r.error = 1'b1;
      end else begin
         case (beat.func)
            brf_pkg::FUNC_READ: begin
               r.read_data = ring_mem[rd_ptr];
               rd_ptr = (rd_ptr + 1 >= s) ? 0 : rd_ptr + 1;
               fill--;
            end
            brf_pkg::FUNC_PEEK_OLDEST: begin
               r.read_data = ring_mem[rd_ptr];
            end
            default: begin
               idx = (wr_ptr == 0) ? s - 1 : wr_ptr - 1;
               r.read_data = ring_mem[idx];
            end
         endcase
      end
      r.free_space = 8'(s - fill - 1);
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken,
   // with valid still high so that a following beat can go out back to back.
   task automatic send_beat(input logic [1:0] func, input logic [7:0] data);
      brf_pkg::req_type beat;
      int      gap;
      beat.func = func;
      beat.write_data = data;
      gap = tx_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = beat;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      awaited_rsp.push_back(predict_fifo_op(beat));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_valid = 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic write_ring_size(input logic [8:0] value);
      drain_all();
      repeat (4) @(negedge clock);
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      ring_size = value;
      wr_ptr = 0;
      rd_ptr = 0;
      fill = 0;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_request > 0) begin
         rx_hold_left = hold_request;
         hold_request = 0;
      end
      if (rx_hold_left > 0) begin
         rsp_stall = 1'b1;
         rx_hold_left--;
      end else if (rx_gap_left > 0) begin
         rsp_stall = 1'b1;
         rx_gap_left--;
      end else if (!rx_idle_on) begin
         rsp_stall = 1'b0;
      end else begin
         rx_gap_left = pick_gap();
         rsp_stall = (rx_gap_left > 0);
         if (rx_gap_left > 0) rx_gap_left--;
      end
   end

   always @(posedge clock) begin
      brf_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response beat %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.read_data !== want.read_data) begin
               $display("%0t: read_data expected %h actual %h",
                        $time, want.read_data, rsp_data.read_data);
               fail_count++;
            end
            if (rsp_data.error !== want.error) begin
               $display("%0t: error expected %b actual %b",
                        $time, want.error, rsp_data.error);
               fail_count++;
            end
            if (rsp_data.free_space !== want.free_space) begin
               $display("%0t: free_space expected %0d actual %0d",
                        $time, want.free_space, rsp_data.free_space);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_basic_ops();
      send_beat(brf_pkg::FUNC_READ, 8'h00);
      send_beat(brf_pkg::FUNC_PEEK_OLDEST, 8'hFF);
      send_beat(brf_pkg::FUNC_PEEK_NEWEST, 8'h00);
      send_beat(brf_pkg::FUNC_WRITE, 8'h00);
      send_beat(brf_pkg::FUNC_PEEK_NEWEST, 8'h00);
      send_beat(brf_pkg::FUNC_WRITE, 8'hFF);
      send_beat(brf_pkg::FUNC_PEEK_NEWEST, 8'h00);
      send_beat(brf_pkg::FUNC_PEEK_OLDEST, 8'h00);
      send_beat(brf_pkg::FUNC_READ, 8'h00);
      send_beat(brf_pkg::FUNC_READ, 8'h00);
      send_beat(brf_pkg::FUNC_READ, 8'h00);
      send_beat(brf_pkg::FUNC_WRITE, 8'hA5);
      drain_all();
      // With a two-slot ring the second write overflows and the third wraps
      // the write pointer back to zero, so the newest peek takes the last slot.
      write_ring_size(9'd2);
      send_beat(brf_pkg::FUNC_WRITE, 8'h5A);
      send_beat(brf_pkg::FUNC_WRITE, 8'h3C);
      send_beat(brf_pkg::FUNC_PEEK_NEWEST, 8'h00);
      send_beat(brf_pkg::FUNC_READ, 8'h00);
      send_beat(brf_pkg::FUNC_WRITE, 8'hC3);
      send_beat(brf_pkg::FUNC_PEEK_NEWEST, 8'h00);
      send_beat(brf_pkg::FUNC_PEEK_OLDEST, 8'h00);
      send_beat(brf_pkg::FUNC_READ, 8'h00);
      drain_all();
   endtask

   task automatic test_size_extremes();
      logic [8:0] sizes [7];
      int         cap;
      int         n;
      sizes = '{9'd0, 9'd1, 9'd3, 9'd257, 9'd511, 9'd255, 9'd256};
      foreach (sizes[i]) begin
         write_ring_size(sizes[i]);
         cap = (sizes[i] < 2) ? 1 : ((sizes[i] > RING_DEPTH) ? RING_DEPTH - 1 : sizes[i] - 1);
         n = (cap + 1 < 6) ? cap + 1 : 6;
         repeat (n) send_beat(brf_pkg::FUNC_WRITE, 8'($urandom_range(0, 255)));
         send_beat(brf_pkg::FUNC_PEEK_NEWEST, 8'h00);
         send_beat(brf_pkg::FUNC_PEEK_OLDEST, 8'h00);
         repeat (n + 1) send_beat(brf_pkg::FUNC_READ, 8'h00);
      end
      drain_all();
   endtask

   task automatic test_backpressure();
      write_ring_size(9'd256);
      tx_idle_on = 1'b0;
      hold_request = 200;
      repeat (32) send_beat(brf_pkg::FUNC_WRITE, 8'($urandom_range(0, 255)));
      tx_idle_on = 1'b1;
      repeat (32) send_beat(brf_pkg::FUNC_READ, 8'h00);
      drain_all();
   endtask

   task automatic test_random_ops();
      int         start;
      int         n;
      int         write_pct;
      int         r;
      logic [1:0] func;
      logic [8:0] size_pick;
      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) begin
         if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(0, 9);
            if (r < 7) size_pick = 9'($urandom_range(2, 12));
            else if (r < 9) size_pick = 9'($urandom_range(13, 256));
            else size_pick = 9'($urandom_range(0, 511));
            write_ring_size(size_pick);
         end else begin
            drain_all();
         end
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         write_pct = $urandom_range(25, 75);
         n = $urandom_range(30, 70);
         if (n > RANDOM_BEATS - (beats_sent - start)) begin
            n = RANDOM_BEATS - (beats_sent - start);
         end
         repeat (n) begin
            if ($urandom_range(0, 99) < write_pct) func = brf_pkg::FUNC_WRITE;
            else func = 2'($urandom_range(1, 3));
            send_beat(func, 8'($urandom_range(0, 255)));
         end
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      drain_all();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_basic_ops();
      test_size_extremes();
      test_backpressure();
      test_random_ops();
      drain_all();
      repeat (12) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
